// ----- hdl/lhcam_pkg.sv -----
`default_nettype none
package lhcam_pkg;

   // Target codes of a result.
   localparam logic [1:0] TARGET_NONE = 2'd0;
   localparam logic [1:0] TARGET_ROM  = 2'd1;
   localparam logic [1:0] TARGET_RAM  = 2'd2;

   // Map modes.
   localparam logic MAP_LOROM = 1'b0;
   localparam logic MAP_HIROM = 1'b1;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BYTES      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAVE_RAM_BYTES = 2'd2;

   localparam int ROM_BYTES_W = 23;
   localparam int RAM_BYTES_W = 20;
   localparam int OFFSET_W    = 22;

   // The ROM remainder is worked out by restoring division, four
   // quotient bits in each pipeline stage.
   localparam int DIV_STEPS  = 4;
   localparam int DIVIDEND_W = 24;
   localparam int DIV_STAGES = DIVIDEND_W / DIV_STEPS;

   typedef struct packed {
      logic [1:0]            target;
      logic [OFFSET_W-1:0]   ram_offset;
      logic [DIVIDEND_W-1:0] dividend;
      logic [OFFSET_W-1:0]   remainder;
      logic                  store_enable;
      logic [7:0]            store_byte;
   } item_type;

endpackage
`default_nettype wire

// ----- hdl/lhcam_decode.sv -----
`default_nettype none
module lhcam_decode (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic                                op,
   input  wire logic [7:0]                          bus_bank,
   input  wire logic [15:0]                         bus_offset,
   input  wire logic [7:0]                          write_byte,
   input  wire logic                                map_mode,
   input  wire logic [lhcam_pkg::ROM_BYTES_W-1:0]   rom_bytes,
   input  wire logic [lhcam_pkg::RAM_BYTES_W-1:0]   save_ram_bytes,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output lhcam_pkg::item_type                      out_item
);

   logic                                 valid_ff;
   lhcam_pkg::item_type                  item_ff;
   lhcam_pkg::item_type                  item_in;
   logic                                 system_low;
   logic                                 ram_present;
   logic                                 ram_hit;
   logic                                 rom_ok;
   logic [18:0]                          ram_raw;
   logic [lhcam_pkg::RAM_BYTES_W-1:0]    ram_mask;
   logic [lhcam_pkg::RAM_BYTES_W-1:0]    ram_masked;
   logic [lhcam_pkg::OFFSET_W-1:0]       rom_off;

   always_comb begin
      // The lower half of banks 00-3F and 80-BF belongs to the system.
      system_low  = !bus_offset[15] && !bus_bank[6];
      ram_present = save_ram_bytes != '0;
      ram_mask    = save_ram_bytes - lhcam_pkg::RAM_BYTES_W'(1);
      if (map_mode == lhcam_pkg::MAP_LOROM) begin
         ram_hit = ((bus_bank >= 8'h70 && bus_bank < 8'h7e) || bus_bank >= 8'hf0) &&
                   !bus_offset[15] && ram_present;
         ram_raw = {bus_bank[3:0], bus_offset[14:0]};
         rom_off = {bus_bank[6:0], bus_offset[14:0]};
      end else begin
         ram_hit = !bus_bank[6] && bus_offset[15:13] == 3'b011 && ram_present;
         ram_raw = {bus_bank[5:0], bus_offset[12:0]};
         rom_off = {bus_bank[5:0], bus_offset};
      end
      ram_masked = {1'b0, ram_raw} & ram_mask;
      rom_ok = !system_low && bus_bank != 8'h7e && bus_bank != 8'h7f && rom_bytes != '0;

      item_in              = '0;
      item_in.dividend     = {2'b00, rom_off};
      if (ram_hit) begin
         item_in.target       = lhcam_pkg::TARGET_RAM;
         item_in.ram_offset   = {2'b00, ram_masked};
         item_in.store_enable = op;
         item_in.store_byte   = op ? write_byte : 8'h00;
      end else if (rom_ok && !op) begin
         item_in.target = lhcam_pkg::TARGET_ROM;
      end else begin
         item_in.target = lhcam_pkg::TARGET_NONE;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/lhcam_div_stage.sv -----
`default_nettype none
module lhcam_div_stage (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire lhcam_pkg::item_type                 in_item,
   input  wire logic [lhcam_pkg::ROM_BYTES_W-1:0]   divisor,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output lhcam_pkg::item_type                      out_item
);

   logic                                  valid_ff;
   lhcam_pkg::item_type                   item_ff;
   lhcam_pkg::item_type                   item_in;
   logic [lhcam_pkg::OFFSET_W-1:0]        rem;
   logic [lhcam_pkg::DIVIDEND_W-1:0]      dvd;
   logic [lhcam_pkg::ROM_BYTES_W-1:0]     trial;

   // Each step brings down one dividend bit; the partial remainder stays
   // below the divisor, so it fits the offset width.
   always_comb begin
      rem = in_item.remainder;
      dvd = in_item.dividend;
      trial = '0;
      for (int k = 0; k < lhcam_pkg::DIV_STEPS; k++) begin
         trial = {rem, dvd[lhcam_pkg::DIVIDEND_W-1]};
         dvd   = {dvd[lhcam_pkg::DIVIDEND_W-2:0], 1'b0};
         if (trial >= divisor) begin
            rem = lhcam_pkg::OFFSET_W'(trial - divisor);
         end else begin
            rem = trial[lhcam_pkg::OFFSET_W-1:0];
         end
      end
      item_in           = in_item;
      item_in.remainder = rem;
      item_in.dividend  = dvd;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/lorom_hirom_cart_address_mapper.sv -----
// Cartridge address mapper for a 24-bit CPU bus, LoROM or HiROM layout.
// The req_ channel carries one bus access per transaction: the access kind
// in req_tuser and bank, offset and write data in req_tdata. The rsp_
// channel returns one transaction per access: the target memory (none,
// ROM or save RAM) and the store flag in rsp_tuser, the linear offset and
// the byte to store in rsp_tdata.
// Configuration is written through csr_we/csr_index/csr_wdata while no
// access is in flight; index 0 is the map mode, 1 the ROM size in bytes and
// 2 the save RAM size in bytes.
// An access passes eight registers: one decode stage, six remainder stages
// that each resolve four bits of the ROM offset modulo the ROM size, and an
// output register. The first is loaded at the accepting edge. One access is
// accepted every cycle unless a low rsp_tready holds the pipeline.
// Each stage has its own valid bit, so when rsp_tready is low the pipeline
// keeps accepting until its empty stages are filled, then holds everything.
// Reset clears the valid bits and sets the map mode to LoROM and both sizes
// to zero, so every access maps to no target until configured.
`default_nettype none
module lorom_hirom_cart_address_mapper (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [7:0] bus_bank, [23:8] bus_offset, [31:24] write_byte
   input  wire logic [31:0]                          req_tdata,
   // [0] op
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [21:0] linear_offset, [29:22] store_byte, [31:30] zero
   output logic [31:0]                               rsp_tdata,
   // [1:0] target, [2] store_enable
   output logic [2:0]                                rsp_tuser,
   input  wire logic                                 csr_we,
   input  wire logic [lhcam_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lhcam_pkg::ROM_BYTES_W-1:0]    csr_wdata
);

   localparam int NSTG = lhcam_pkg::DIV_STAGES;

   logic                                 map_mode_ff;
   logic [lhcam_pkg::ROM_BYTES_W-1:0]    rom_bytes_ff;
   logic [lhcam_pkg::RAM_BYTES_W-1:0]    save_ram_bytes_ff;

   logic                                 stg_valid [NSTG+1];
   logic                                 stg_ready [NSTG+1];
   lhcam_pkg::item_type                  stg_item  [NSTG+1];

   logic                                 out_ready;
   logic                                 rsp_valid_ff;
   logic [1:0]                           target_ff;
   logic [lhcam_pkg::OFFSET_W-1:0]       offset_ff;
   logic                                 store_enable_ff;
   logic [7:0]                           store_byte_ff;
   logic [lhcam_pkg::OFFSET_W-1:0]       offset_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff       <= lhcam_pkg::MAP_LOROM;
         rom_bytes_ff      <= '0;
         save_ram_bytes_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lhcam_pkg::CSR_MAP_MODE:       map_mode_ff <= csr_wdata[0];
            lhcam_pkg::CSR_ROM_BYTES:      rom_bytes_ff <= csr_wdata;
            lhcam_pkg::CSR_SAVE_RAM_BYTES: begin
               save_ram_bytes_ff <= csr_wdata[lhcam_pkg::RAM_BYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   lhcam_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .op             (req_tuser),
      .bus_bank       (req_tdata[7:0]),
      .bus_offset     (req_tdata[23:8]),
      .write_byte     (req_tdata[31:24]),
      .map_mode       (map_mode_ff),
      .rom_bytes      (rom_bytes_ff),
      .save_ram_bytes (save_ram_bytes_ff),
      .out_valid      (stg_valid[0]),
      .out_ready      (stg_ready[0]),
      .out_item       (stg_item[0])
   );

   for (genvar s = 0; s < NSTG; s++) begin : g_div
      lhcam_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_item   (stg_item[s]),
         .divisor   (rom_bytes_ff),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_item  (stg_item[s+1])
      );
   end

   assign out_ready        = !rsp_valid_ff || rsp_tready;
   assign stg_ready[NSTG]  = out_ready;

   always_comb begin
      if (stg_item[NSTG].target == lhcam_pkg::TARGET_ROM) begin
         offset_in = stg_item[NSTG].remainder;
      end else begin
         offset_in = stg_item[NSTG].ram_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stg_valid[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_valid[NSTG]) begin
         target_ff       <= stg_item[NSTG].target;
         offset_ff       <= offset_in;
         store_enable_ff <= stg_item[NSTG].store_enable;
         store_byte_ff   <= stg_item[NSTG].store_byte;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, store_byte_ff, offset_ff};
   assign rsp_tuser  = {store_enable_ff, target_ff};

   a_store_only_ram: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && store_enable_ff |-> target_ff == lhcam_pkg::TARGET_RAM)
      else $error("store enable raised for a target other than save RAM");

   a_none_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && target_ff == lhcam_pkg::TARGET_NONE |-> offset_ff == '0)
      else $error("unmapped access carries a nonzero offset");

   a_target_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> target_ff == lhcam_pkg::TARGET_NONE ||
                       target_ff == lhcam_pkg::TARGET_ROM ||
                       target_ff == lhcam_pkg::TARGET_RAM)
      else $error("result carries an undefined target code");

   a_rom_offset_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && target_ff == lhcam_pkg::TARGET_ROM &&
      $stable(rom_bytes_ff) |-> {1'b0, offset_ff} < rom_bytes_ff)
      else $error("ROM offset not below the ROM size");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam string PASS_TEXT = "** lorom_hirom_cart_address_mapper: PASSED **";
   localparam string FAIL_TEXT = "** lorom_hirom_cart_address_mapper: FAILED **";

   typedef struct packed {
      logic        op;
      logic [7:0]  bank;
      logic [15:0] addr;
      logic [7:0]  wbyte;
   } bus_access_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [21:0] offset;
      logic        store_en;
      logic [7:0]  store_byte;
   } cart_hit_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [31:0]                       req_tdata = '0;
   logic                              req_tuser = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [31:0]                       rsp_tdata;
   logic [2:0]                        rsp_tuser;
   logic                              csr_we = 1'b0;
   logic [lhcam_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lhcam_pkg::ROM_BYTES_W-1:0] csr_wdata = '0;

   lorom_hirom_cart_address_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the mapper's configuration.
   logic                              cfg_map = lhcam_pkg::MAP_LOROM;
   logic [lhcam_pkg::ROM_BYTES_W-1:0] cfg_rom = '0;
   logic [lhcam_pkg::RAM_BYTES_W-1:0] cfg_ram = '0;

   bus_access_type access_q[$];
   cart_hit_type   expected_hits_q[$];
   bus_access_type drv_access;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned failures = 0;

   function automatic cart_hit_type map_access(bus_access_type a);
      logic [7:0]   canon;
      logic         ram_hit;
      logic         rom_ok;
      logic [31:0]  ram_off;
      logic [31:0]  rom_off;
      cart_hit_type r;
      canon = {1'b0, a.bank[6:0]};
      if (cfg_map == lhcam_pkg::MAP_LOROM) begin
         ram_hit = ((a.bank >= 8'h70 && a.bank < 8'h7e) || a.bank >= 8'hf0) &&
                   a.addr < 16'h8000 && cfg_ram != 0;
         ram_off = (32'(a.bank[3:0]) << 15) | 32'(a.addr);
         rom_off = (32'(canon) << 15) | 32'(a.addr[14:0]);
      end else begin
         ram_hit = canon < 8'h40 && a.addr >= 16'h6000 && a.addr < 16'h8000 &&
                   cfg_ram != 0;
         ram_off = (32'(canon[5:0]) << 13) | 32'(a.addr[12:0]);
         rom_off = (32'(canon[5:0]) << 16) | 32'(a.addr);
      end
      // The low half of a system bank never reaches ROM in either layout.
      rom_ok = !(a.addr < 16'h8000 && canon < 8'h40) && a.bank != 8'h7e &&
               a.bank != 8'h7f && cfg_rom != 0;
      r = '0;
      r.target = lhcam_pkg::TARGET_NONE;
      if (ram_hit) begin
         r.target = lhcam_pkg::TARGET_RAM;
         r.offset = 22'(ram_off & (32'(cfg_ram) - 32'd1));
      end else if (rom_ok && a.op == OP_READ) begin
         r.target = lhcam_pkg::TARGET_ROM;
         r.offset = 22'(rom_off % 32'(cfg_rom));
      end
      if (a.op == OP_WRITE && r.target == lhcam_pkg::TARGET_RAM) begin
         r.store_en = 1'b1;
         r.store_byte = a.wbyte;
      end
      return r;
   endfunction

   task automatic flag_failure(string what, cart_hit_type want, cart_hit_type got);
      failures++;
      if (failures <= 10)
         $display({"%0t: %s: expected target %0d offset %h store %b byte %h, ",
                   "got target %0d offset %h store %b byte %h"},
                  $realtime, what, want.target, want.offset, want.store_en,
                  want.store_byte, got.target, got.offset, got.store_en,
                  got.store_byte);
   endtask

   // Driver: the expectation is worked out when the transaction is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_hits_q.push_back(map_access(drv_access));
         if (!req_tvalid || req_tready) begin
            if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_access = access_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {drv_access.wbyte, drv_access.addr, drv_access.bank};
               req_tuser <= drv_access.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      cart_hit_type got;
      cart_hit_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.target = rsp_tuser[1:0];
            got.store_en = rsp_tuser[2];
            got.offset = rsp_tdata[21:0];
            got.store_byte = rsp_tdata[29:22];
            if (expected_hits_q.size() == 0) begin
               flag_failure("unexpected result", '0, got);
            end else begin
               want = expected_hits_q.pop_front();
               if (got.target != want.target || got.offset != want.offset ||
                   got.store_en != want.store_en || got.store_byte != want.store_byte)
                  flag_failure("mismatch", want, got);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_csr(logic [lhcam_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lhcam_pkg::ROM_BYTES_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lhcam_pkg::CSR_MAP_MODE:       cfg_map = val[0];
         lhcam_pkg::CSR_ROM_BYTES:      cfg_rom = val;
         lhcam_pkg::CSR_SAVE_RAM_BYTES: cfg_ram = val[lhcam_pkg::RAM_BYTES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_layout(logic map, logic [22:0] rom, logic [22:0] ram);
      write_csr(lhcam_pkg::CSR_MAP_MODE, {22'd0, map});
      write_csr(lhcam_pkg::CSR_ROM_BYTES, rom);
      write_csr(lhcam_pkg::CSR_SAVE_RAM_BYTES, ram);
   endtask

   task automatic queue_access(logic op, logic [7:0] bank, logic [15:0] addr,
                               logic [7:0] wbyte);
      access_q.push_back('{op, bank, addr, wbyte});
   endtask

   // Banks and offsets near the region boundaries are favored.
   task automatic queue_random_access();
      logic [7:0]  bank;
      logic [15:0] addr;
      logic [7:0]  edge_banks[14];
      logic [15:0] edge_addrs[8];
      edge_banks = '{8'h00, 8'h3f, 8'h40, 8'h6f, 8'h70, 8'h7d, 8'h7e,
                     8'h7f, 8'h80, 8'hbf, 8'hc0, 8'hef, 8'hf0, 8'hff};
      edge_addrs = '{16'h0000, 16'h5fff, 16'h6000, 16'h7fff,
                     16'h8000, 16'hffff, 16'h6abc, 16'h1234};
      bank = ($urandom_range(2) == 0) ? edge_banks[$urandom_range(13)] : 8'($urandom);
      addr = ($urandom_range(2) == 0) ? edge_addrs[$urandom_range(7)] : 16'($urandom);
      queue_access(1'($urandom), bank, addr, 8'($urandom));
   endtask

   task automatic wait_drained();
      while (access_q.size() != 0 || req_tvalid || expected_hits_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      #5_000_000;
      $display(FAIL_TEXT);
      $finish;
   end

   initial begin
      logic        map;
      logic [22:0] rom;
      logic [22:0] ram;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Out of reset nothing is mapped: no ROM and no save RAM.
      queue_access(OP_READ, 8'h00, 16'h8000, 8'h00);
      queue_access(OP_WRITE, 8'h70, 16'h0000, 8'h5a);
      queue_access(OP_READ, 8'hc0, 16'h0000, 8'h00);
      wait_drained();

      set_layout(lhcam_pkg::MAP_LOROM, 23'h400000, 23'h80000);
      queue_access(OP_READ, 8'h00, 16'h0000, 8'h00);
      queue_access(OP_READ, 8'h00, 16'h8000, 8'h00);
      queue_access(OP_READ, 8'hff, 16'hffff, 8'h00);
      queue_access(OP_WRITE, 8'h80, 16'h8000, 8'h33);
      queue_access(OP_READ, 8'h7e, 16'h1234, 8'h00);
      queue_access(OP_WRITE, 8'h7f, 16'hffff, 8'hff);
      queue_access(OP_READ, 8'h70, 16'h0000, 8'h00);
      queue_access(OP_WRITE, 8'hf0, 16'h7fff, 8'hff);
      queue_access(OP_WRITE, 8'h7d, 16'h7fff, 8'ha5);
      queue_access(OP_READ, 8'h40, 16'h0000, 8'h00);
      queue_access(OP_READ, 8'hc0, 16'h7fff, 8'h00);
      wait_drained();

      set_layout(lhcam_pkg::MAP_HIROM, 23'h400000, 23'h2000);
      queue_access(OP_READ, 8'h00, 16'h6000, 8'h00);
      queue_access(OP_WRITE, 8'hbf, 16'h7fff, 8'h81);
      queue_access(OP_READ, 8'h3f, 16'h5fff, 8'h00);
      queue_access(OP_READ, 8'hc0, 16'h0000, 8'h00);
      queue_access(OP_READ, 8'hff, 16'hffff, 8'h00);
      queue_access(OP_WRITE, 8'h40, 16'h0000, 8'h11);
      queue_access(OP_READ, 8'h7e, 16'h8000, 8'h00);
      queue_access(OP_READ, 8'h80, 16'h8000, 8'h00);
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         map = 1'($urandom);
         case ($urandom_range(3))
            0: rom = '0;
            1: rom = 23'($urandom_range(1, 32'h400000));
            2: rom = 23'($urandom_range(1, 65535));
            default: rom = 23'h400000 >> $urandom_range(0, 12);
         endcase
         case ($urandom_range(2))
            0: ram = '0;
            1: ram = 23'(32'd1 << $urandom_range(0, 19));
            default: ram = 23'($urandom_range(1, 524288));
         endcase
         case (phase)
            0: set_layout(lhcam_pkg::MAP_LOROM, 23'h400000, 23'h80000);
            1: set_layout(lhcam_pkg::MAP_HIROM, 23'h400000, 23'h80000);
            2: set_layout(lhcam_pkg::MAP_LOROM, 23'h3fffff, 23'h7ffff);
            3: set_layout(lhcam_pkg::MAP_HIROM, 23'h3fffff, 23'h7ffff);
            4: set_layout(lhcam_pkg::MAP_LOROM, 23'd1, 23'd1);
            5: set_layout(lhcam_pkg::MAP_HIROM, 23'd0, 23'd0);
            default: set_layout(map, rom, ram);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         repeat (24) queue_random_access();
         // The sender holds off here until the pipeline has emptied.
         wait_drained();
         repeat (24) queue_random_access();
         wait_drained();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      repeat (20) @(posedge clock);
      failures += expected_hits_q.size();
      if (failures == 0) begin
         $display(PASS_TEXT);
      end else begin
         $display(FAIL_TEXT);
      end
      $finish;
   end

endmodule
`default_nettype wire
